// ----- hdl/lpc_pkg.sv -----
// shared types, constants and helper functions of the led pixel color stage
`default_nettype none

package lpc_pkg;

    localparam int unsigned CHAN_W     = 8;
    localparam int unsigned SECTOR_W   = 3;
    localparam int unsigned HUE_SPAN   = 43;
    localparam int unsigned CHAN_MAX   = 255;
    localparam int unsigned HSV_STAGES = 3;

    // hue sector codes
    localparam logic [SECTOR_W-1:0] SEC_RED_YEL  = 3'd0;
    localparam logic [SECTOR_W-1:0] SEC_YEL_GRN  = 3'd1;
    localparam logic [SECTOR_W-1:0] SEC_GRN_CYN  = 3'd2;
    localparam logic [SECTOR_W-1:0] SEC_CYN_BLU  = 3'd3;
    localparam logic [SECTOR_W-1:0] SEC_BLU_MAG  = 3'd4;
    localparam logic [SECTOR_W-1:0] SEC_MAG_RED  = 3'd5;

    typedef struct packed {
        logic [CHAN_W-1:0] blu;
        logic [CHAN_W-1:0] grn;
        logic [CHAN_W-1:0] red;
    } t_rgb;

    // hue divided by the sector span, as a row of compares
    function automatic logic [SECTOR_W-1:0] hue_sector(input logic [CHAN_W-1:0] hue);
        logic [SECTOR_W-1:0] sec;
        sec = '0;
        for (int k = 1; k <= 5; k++) begin
            if (hue >= CHAN_W'(k * HUE_SPAN)) begin
                sec = SECTOR_W'(k);
            end
        end
        return sec;
    endfunction

    // first hue of a sector
    function automatic logic [CHAN_W-1:0] sector_base(input logic [SECTOR_W-1:0] sec);
        logic [CHAN_W-1:0] base;
        unique case (sec)
            SEC_RED_YEL: base = CHAN_W'(0);
            SEC_YEL_GRN: base = CHAN_W'(HUE_SPAN);
            SEC_GRN_CYN: base = CHAN_W'(2 * HUE_SPAN);
            SEC_CYN_BLU: base = CHAN_W'(3 * HUE_SPAN);
            SEC_BLU_MAG: base = CHAN_W'(4 * HUE_SPAN);
            default:     base = CHAN_W'(5 * HUE_SPAN);
        endcase
        return base;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/lpc_hsv.sv -----
// three stage integer hsv to rgb converter for one hue
`default_nettype none

module lpc_hsv (
    input  wire logic                                  i_clk,
    input  wire logic [lpc_pkg::HSV_STAGES-1:0]        i_ce,
    input  wire logic [lpc_pkg::CHAN_W-1:0]            i_hue,
    input  wire logic [lpc_pkg::CHAN_W-1:0]            i_sat,
    input  wire logic [lpc_pkg::CHAN_W-1:0]            i_val,
    output      lpc_pkg::t_rgb                         o_rgb
);
    import lpc_pkg::*;

    localparam int unsigned PROD_W = 2 * CHAN_W;

    logic [SECTOR_W-1:0] n1_sec;
    logic [CHAN_W-1:0]   n1_off;
    logic [CHAN_W-1:0]   n1_frac;
    logic [PROD_W-1:0]   n2_sf, n2_st;
    logic [PROD_W-1:0]   n3_q, n3_t;

    logic [SECTOR_W-1:0] r1_sec, r2_sec, r3_sec;
    logic [CHAN_W-1:0]   r1_frac;
    logic [PROD_W-1:0]   r1_pv;
    logic [CHAN_W-1:0]   r1_sat, r1_val, r2_val, r3_val;
    logic [CHAN_W-1:0]   r2_sf, r2_st, r2_p;
    logic                r2_gray, r3_gray;
    logic [CHAN_W-1:0]   r3_p, r3_q, r3_t;

    // stage 1: sector, fraction times six, v*(255-s)
    always_comb begin
        n1_sec  = hue_sector(i_hue);
        n1_off  = i_hue - sector_base(n1_sec);
        n1_frac = (n1_off << 2) + (n1_off << 1);
    end

    always_ff @(posedge i_clk) begin
        if (i_ce[0]) begin
            r1_sec  <= n1_sec;
            r1_frac <= n1_frac;
            r1_pv   <= i_val * (CHAN_W'(CHAN_MAX) - i_sat);
            r1_sat  <= i_sat;
            r1_val  <= i_val;
        end
    end

    // stage 2: saturation times fraction and its complement
    always_comb begin
        n2_sf = r1_sat * r1_frac;
        n2_st = r1_sat * (CHAN_W'(CHAN_MAX) - r1_frac);
    end

    always_ff @(posedge i_clk) begin
        if (i_ce[1]) begin
            r2_sec  <= r1_sec;
            r2_sf   <= n2_sf[PROD_W-1:CHAN_W];
            r2_st   <= n2_st[PROD_W-1:CHAN_W];
            r2_p    <= r1_pv[PROD_W-1:CHAN_W];
            r2_val  <= r1_val;
            r2_gray <= (r1_sat == '0);
        end
    end

    // stage 3: falling and rising ramps
    always_comb begin
        n3_q = r2_val * (CHAN_W'(CHAN_MAX) - r2_sf);
        n3_t = r2_val * (CHAN_W'(CHAN_MAX) - r2_st);
    end

    always_ff @(posedge i_clk) begin
        if (i_ce[2]) begin
            r3_sec  <= r2_sec;
            r3_p    <= r2_p;
            r3_q    <= n3_q[PROD_W-1:CHAN_W];
            r3_t    <= n3_t[PROD_W-1:CHAN_W];
            r3_val  <= r2_val;
            r3_gray <= r2_gray;
        end
    end

    // pick channel order by sector, grey when saturation is zero
    always_comb begin
        if (r3_gray) begin
            o_rgb = '{blu: r3_val, grn: r3_val, red: r3_val};
        end else begin
            unique case (r3_sec)
                SEC_RED_YEL: o_rgb = '{blu: r3_p,   grn: r3_t,   red: r3_val};
                SEC_YEL_GRN: o_rgb = '{blu: r3_p,   grn: r3_val, red: r3_q};
                SEC_GRN_CYN: o_rgb = '{blu: r3_t,   grn: r3_val, red: r3_p};
                SEC_CYN_BLU: o_rgb = '{blu: r3_val, grn: r3_q,   red: r3_p};
                SEC_BLU_MAG: o_rgb = '{blu: r3_val, grn: r3_p,   red: r3_t};
                default:     o_rgb = '{blu: r3_q,   grn: r3_p,   red: r3_val};
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- hdl/led_pixel_color_stage.sv -----
// top level of the led pixel color stage: hsv, blend and brightness pipeline
//
// One pixel request enters on the s_axis side and one scaled rgb request
// leaves on the m_axis side for each. s_axis_tuser is the pixel mode
// (0 static color passes through, 1 rainbow blend of two hues); s_axis_tdata
// carries the static color, the two hues, saturation, value, blend and
// brightness. m_axis_tdata carries red, green and blue.
// A new request is taken every cycle unless m_axis_tready stalls the pipeline.
// The six stages are: sector and v*(255-s), saturation products,
// ramp products, blend product, blend add, brightness product. Every stage has
// its own valid bit and advances when it is empty or when the stage after it
// advances, so a stalled receiver fills the bubbles first and only then drops
// s_axis_tready; nothing is lost or repeated.
// Reset (i_rst_n low, synchronous) clears all valid bits; the pipeline is
// empty and ready in the first cycle after reset.
`default_nettype none

module led_pixel_color_stage (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output      logic        s_axis_tready,
    // static_red, static_green, static_blue, hue_current, hue_previous,
    // saturation, value_level, blend, brightness
    input  wire logic [71:0] s_axis_tdata,
    // pixel_mode
    input  wire logic        s_axis_tuser,
    output      logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // out_red, out_green, out_blue
    output      logic [23:0] m_axis_tdata
);
    import lpc_pkg::*;

    localparam int unsigned STAGES = 6;
    localparam int unsigned DIFF_W = CHAN_W + 2;
    localparam int unsigned MIX_W  = CHAN_W + DIFF_W + 1;
    localparam int unsigned SCL_W  = 2 * CHAN_W + 1;

    // input fields
    t_rgb              in_static;
    logic [CHAN_W-1:0] in_hue_cur, in_hue_prev, in_sat, in_val, in_blend, in_bright;

    assign in_static   = '{blu: s_axis_tdata[23:16], grn: s_axis_tdata[15:8],
                           red: s_axis_tdata[7:0]};
    assign in_hue_cur  = s_axis_tdata[31:24];
    assign in_hue_prev = s_axis_tdata[39:32];
    assign in_sat      = s_axis_tdata[47:40];
    assign in_val      = s_axis_tdata[55:48];
    assign in_blend    = s_axis_tdata[63:56];
    assign in_bright   = s_axis_tdata[71:64];

    // stage valid bits and load enables
    logic [STAGES:1] r_vld;
    logic [STAGES:1] ce;

    always_comb begin
        ce[STAGES] = !r_vld[STAGES] || m_axis_tready;
        for (int k = STAGES - 1; k >= 1; k--) begin
            ce[k] = !r_vld[k] || ce[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (ce[1]) begin
                r_vld[1] <= s_axis_tvalid;
            end
            for (int k = 2; k <= STAGES; k++) begin
                if (ce[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign s_axis_tready = ce[1];
    assign m_axis_tvalid = r_vld[STAGES];

    // stages 1 to 3: two hue converters
    t_rgb hsv_a, hsv_b;

    lpc_hsv u_hsv_cur (
        .i_clk (i_clk),
        .i_ce  (ce[HSV_STAGES:1]),
        .i_hue (in_hue_cur),
        .i_sat (in_sat),
        .i_val (in_val),
        .o_rgb (hsv_a)
    );

    lpc_hsv u_hsv_prev (
        .i_clk (i_clk),
        .i_ce  (ce[HSV_STAGES:1]),
        .i_hue (in_hue_prev),
        .i_sat (in_sat),
        .i_val (in_val),
        .o_rgb (hsv_b)
    );

    // side band travelling alongside the converters
    logic [HSV_STAGES:1]             r_mode;
    t_rgb                            r_static [HSV_STAGES:1];
    logic [CHAN_W-1:0]               r_blend  [HSV_STAGES:1];
    logic [CHAN_W-1:0]               r_bright [HSV_STAGES:1];

    always_ff @(posedge i_clk) begin
        if (ce[1]) begin
            r_mode[1]   <= s_axis_tuser;
            r_static[1] <= in_static;
            r_blend[1]  <= in_blend;
            r_bright[1] <= in_bright;
        end
        for (int k = 2; k <= HSV_STAGES; k++) begin
            if (ce[k]) begin
                r_mode[k]   <= r_mode[k-1];
                r_static[k] <= r_static[k-1];
                r_blend[k]  <= r_blend[k-1];
                r_bright[k] <= r_bright[k-1];
            end
        end
    end

    // stage 4: blend product x*(b-a+1)+1 per channel
    logic [CHAN_W-1:0]        a_ch [3];
    logic [CHAN_W-1:0]        b_ch [3];
    logic signed [DIFF_W-1:0] n4_diff [3];
    logic signed [MIX_W-1:0]  n4_prod [3];

    logic signed [MIX_W-1:0]  r4_prod [3];
    logic [CHAN_W-1:0]        r4_a    [3];
    logic                     r4_mode;
    t_rgb                     r4_static;
    logic [CHAN_W-1:0]        r4_bright;

    always_comb begin
        a_ch[0] = hsv_a.red;
        a_ch[1] = hsv_a.grn;
        a_ch[2] = hsv_a.blu;
        b_ch[0] = hsv_b.red;
        b_ch[1] = hsv_b.grn;
        b_ch[2] = hsv_b.blu;
        for (int c = 0; c < 3; c++) begin
            n4_diff[c] = $signed({2'b00, b_ch[c]}) - $signed({2'b00, a_ch[c]})
                         + $signed(DIFF_W'(1));
            n4_prod[c] = $signed({1'b0, r_blend[HSV_STAGES]}) * n4_diff[c]
                         + $signed(MIX_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce[4]) begin
            for (int c = 0; c < 3; c++) begin
                r4_prod[c] <= n4_prod[c];
                r4_a[c]    <= a_ch[c];
            end
            r4_mode   <= r_mode[HSV_STAGES];
            r4_static <= r_static[HSV_STAGES];
            r4_bright <= r_bright[HSV_STAGES];
        end
    end

    // stage 5: floor shift, add and mode select
    logic [CHAN_W-1:0] n5_mix [3];
    logic [CHAN_W-1:0] r5_col [3];
    logic [CHAN_W-1:0] r5_bright;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n5_mix[c] = r4_a[c] + r4_prod[c][2*CHAN_W-1:CHAN_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce[5]) begin
            if (r4_mode) begin
                for (int c = 0; c < 3; c++) begin
                    r5_col[c] <= n5_mix[c];
                end
            end else begin
                r5_col[0] <= r4_static.red;
                r5_col[1] <= r4_static.grn;
                r5_col[2] <= r4_static.blu;
            end
            r5_bright <= r4_bright;
        end
    end

    // stage 6: brightness scale y*c + y + 1
    logic [SCL_W-1:0]  n6_scl [3];
    logic [CHAN_W-1:0] r6_out [3];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n6_scl[c] = r5_bright * r5_col[c] + SCL_W'(r5_bright) + SCL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce[6]) begin
            for (int c = 0; c < 3; c++) begin
                r6_out[c] <= n6_scl[c][2*CHAN_W-1:CHAN_W];
            end
        end
    end

    assign m_axis_tdata = {r6_out[2], r6_out[1], r6_out[0]};

endmodule

`default_nettype wire
